>>> rtl/lrwcg_pkg.sv
// ----------------------------------------------------------------------------
// lrwcg_pkg: shared types and constants of the rotated window command generator
// Holds the channel payload structs, the queued job descriptor, the panel
// register indexes and the rotation codes.
// ----------------------------------------------------------------------------
package lrwcg_pkg;

    localparam int COORD_W   = 10;
    localparam int BUS_W     = 16;
    localparam int COUNT_W   = 17;
    localparam int AREA_W    = 2 * (COORD_W + 1);
    localparam int STEP_W    = 5;
    localparam int WIN_WORDS = 12;
    localparam int MAX_WORDS = 18;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 17'h1FFFF;

    localparam logic [BUS_W-1:0] CMD_CURSOR_X    = 16'h0020;
    localparam logic [BUS_W-1:0] CMD_CURSOR_Y    = 16'h0021;
    localparam logic [BUS_W-1:0] CMD_RAM         = 16'h0022;
    localparam logic [BUS_W-1:0] CMD_WIN_X_START = 16'h0050;
    localparam logic [BUS_W-1:0] CMD_WIN_X_END   = 16'h0051;
    localparam logic [BUS_W-1:0] CMD_WIN_Y_START = 16'h0052;
    localparam logic [BUS_W-1:0] CMD_WIN_Y_END   = 16'h0053;

    typedef enum logic [1:0] {
        ROT_0   = 2'd0,
        ROT_90  = 2'd1,
        ROT_180 = 2'd2,
        ROT_270 = 2'd3
    } t_rotation;

    typedef enum logic [1:0] {
        JOB_PIXEL         = 2'd0,
        JOB_PIXEL_RESTORE = 2'd1,
        JOB_FILL          = 2'd2
    } t_job_kind;

    typedef struct packed {
        logic        op;
        logic [8:0]  x_low;
        logic [8:0]  y_low;
        logic [8:0]  x_high;
        logic [8:0]  y_high;
        logic [15:0] color;
    } t_in_item;

    typedef struct packed {
        logic               is_command;
        logic [BUS_W-1:0]   bus_word;
        logic [COUNT_W-1:0] repeat_count;
        logic               last;
    } t_out_item;

    typedef struct packed {
        logic [COORD_W-1:0] xs;
        logic [COORD_W-1:0] ys;
        logic [COORD_W-1:0] xe;
        logic [COORD_W-1:0] ye;
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
    } t_window;

    typedef struct packed {
        t_job_kind          kind;
        logic [BUS_W-1:0]   color;
        t_window            win;
        logic [COORD_W-1:0] pix_cx;
        logic [COORD_W-1:0] pix_cy;
        logic [AREA_W-1:0]  area;
    } t_job;

endpackage

>>> rtl/lrwcg_front.sv
// ----------------------------------------------------------------------------
// lrwcg_front: request intake and classification
// Clamps and orders the edges, tracks whether the window is narrowed, maps
// the window and cursor onto the panel and computes the fill pixel count.
// ----------------------------------------------------------------------------
module lrwcg_front #(
    parameter int PANEL_WIDTH  = 240,
    parameter int PANEL_HEIGHT = 320
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lrwcg_pkg::t_rotation i_rotation,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  lrwcg_pkg::t_in_item i_in_data,
    output logic                o_job_valid,
    input  logic                i_job_ready,
    output lrwcg_pkg::t_job     o_job
);

    localparam logic [lrwcg_pkg::COORD_W-1:0] W_MAX = lrwcg_pkg::COORD_W'(PANEL_WIDTH - 1);
    localparam logic [lrwcg_pkg::COORD_W-1:0] H_MAX = lrwcg_pkg::COORD_W'(PANEL_HEIGHT - 1);

    function automatic logic [lrwcg_pkg::COORD_W-1:0] clamp(
        input logic [8:0]                   v,
        input logic [lrwcg_pkg::COORD_W-1:0] lim
    );
        logic [lrwcg_pkg::COORD_W-1:0] ve;
        ve = lrwcg_pkg::COORD_W'(v);
        return (ve > lim) ? lim : ve;
    endfunction

    function automatic lrwcg_pkg::t_window map_win(
        input lrwcg_pkg::t_rotation          rot,
        input logic [lrwcg_pkg::COORD_W-1:0] lx,
        input logic [lrwcg_pkg::COORD_W-1:0] ly,
        input logic [lrwcg_pkg::COORD_W-1:0] hx,
        input logic [lrwcg_pkg::COORD_W-1:0] hy
    );
        lrwcg_pkg::t_window w;
        unique case (rot)
            lrwcg_pkg::ROT_90: begin
                w.xs = W_MAX - hy;
                w.xe = W_MAX - ly;
                w.ys = lx;
                w.ye = hx;
                w.cx = W_MAX - ly;
                w.cy = lx;
            end
            lrwcg_pkg::ROT_180: begin
                w.xs = W_MAX - hx;
                w.xe = W_MAX - lx;
                w.ys = H_MAX - hy;
                w.ye = H_MAX - ly;
                w.cx = W_MAX - lx;
                w.cy = H_MAX - ly;
            end
            lrwcg_pkg::ROT_270: begin
                w.xs = ly;
                w.xe = hy;
                w.ys = H_MAX - hx;
                w.ye = H_MAX - lx;
                w.cx = ly;
                w.cy = H_MAX - lx;
            end
            lrwcg_pkg::ROT_0: begin
                w.xs = lx;
                w.xe = hx;
                w.ys = ly;
                w.ye = hy;
                w.cx = lx;
                w.cy = ly;
            end
        endcase
        return w;
    endfunction

    logic                          r_narrowed;
    logic                          r_a_valid;
    lrwcg_pkg::t_job_kind          r_a_kind;
    lrwcg_pkg::t_rotation          r_a_rot;
    logic [lrwcg_pkg::COORD_W-1:0] r_a_lx, r_a_ly, r_a_hx, r_a_hy;
    logic [lrwcg_pkg::COORD_W-1:0] r_a_px, r_a_py;
    logic [lrwcg_pkg::BUS_W-1:0]   r_a_color;
    logic                          r_b_valid;
    lrwcg_pkg::t_job               r_b_job;

    logic                          a_load;
    logic                          b_advance;
    logic                          swap_axes;
    logic [lrwcg_pkg::COORD_W-1:0] lw_max, lh_max;
    logic [lrwcg_pkg::COORD_W-1:0] cxl, cyl, cxh, cyh;
    lrwcg_pkg::t_job_kind          n_a_kind;
    lrwcg_pkg::t_window            pix_win;
    logic [lrwcg_pkg::COORD_W:0]   ext_x, ext_y;
    lrwcg_pkg::t_job               n_b_job;

    assign b_advance   = !r_b_valid || i_job_ready;
    assign o_in_ready  = !r_a_valid || b_advance;
    assign a_load      = i_in_valid && o_in_ready;
    assign o_job_valid = r_b_valid;
    assign o_job       = r_b_job;

    always_comb begin
        swap_axes = (i_rotation == lrwcg_pkg::ROT_90) || (i_rotation == lrwcg_pkg::ROT_270);
        lw_max    = swap_axes ? H_MAX : W_MAX;
        lh_max    = swap_axes ? W_MAX : H_MAX;
        cxl       = clamp(i_in_data.x_low, lw_max);
        cyl       = clamp(i_in_data.y_low, lh_max);
        cxh       = clamp(i_in_data.x_high, lw_max);
        cyh       = clamp(i_in_data.y_high, lh_max);
        if (i_in_data.op) begin
            n_a_kind = lrwcg_pkg::JOB_FILL;
        end else if (r_narrowed) begin
            n_a_kind = lrwcg_pkg::JOB_PIXEL_RESTORE;
        end else begin
            n_a_kind = lrwcg_pkg::JOB_PIXEL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid  <= 1'b0;
            r_narrowed <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_a_valid <= i_in_valid;
            end
            if (a_load) begin
                r_narrowed <= i_in_data.op;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_load) begin
            r_a_kind  <= n_a_kind;
            r_a_rot   <= i_rotation;
            r_a_px    <= cxl;
            r_a_py    <= cyl;
            r_a_color <= i_in_data.color;
            if (i_in_data.op) begin
                r_a_lx <= (cxl > cxh) ? cxh : cxl;
                r_a_hx <= (cxl > cxh) ? cxl : cxh;
                r_a_ly <= (cyl > cyh) ? cyh : cyl;
                r_a_hy <= (cyl > cyh) ? cyl : cyh;
            end else begin
                r_a_lx <= '0;
                r_a_ly <= '0;
                r_a_hx <= lw_max;
                r_a_hy <= lh_max;
            end
        end
    end

    always_comb begin
        pix_win        = map_win(r_a_rot, r_a_px, r_a_py, r_a_px, r_a_py);
        ext_x          = {1'b0, r_a_hx} - {1'b0, r_a_lx} + (lrwcg_pkg::COORD_W + 1)'(1);
        ext_y          = {1'b0, r_a_hy} - {1'b0, r_a_ly} + (lrwcg_pkg::COORD_W + 1)'(1);
        n_b_job.kind   = r_a_kind;
        n_b_job.color  = r_a_color;
        n_b_job.win    = map_win(r_a_rot, r_a_lx, r_a_ly, r_a_hx, r_a_hy);
        n_b_job.pix_cx = pix_win.cx;
        n_b_job.pix_cy = pix_win.cy;
        n_b_job.area   = lrwcg_pkg::AREA_W'(ext_x) * lrwcg_pkg::AREA_W'(ext_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_advance) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_advance && r_a_valid) begin
            r_b_job <= n_b_job;
        end
    end

    a_fill_narrows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        a_load && i_in_data.op |=> r_narrowed)
        else $error("fill request did not mark the window as narrowed");

endmodule

>>> rtl/lrwcg_queue.sv
// ----------------------------------------------------------------------------
// lrwcg_queue: job queue between front and back
// A short first-in first-out buffer of job descriptors; the head is read
// directly so that the back can start a job as soon as it arrives.
// ----------------------------------------------------------------------------
module lrwcg_queue #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    output logic            o_push_ready,
    input  lrwcg_pkg::t_job i_push_job,
    output logic            o_pop_valid,
    input  logic            i_pop,
    output lrwcg_pkg::t_job o_pop_job
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    lrwcg_pkg::t_job r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]   r_count;

    logic push_ok, pop_ok;

    assign o_push_ready = (r_count != CW'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign push_ok      = i_push_valid && o_push_ready;
    assign pop_ok       = i_pop && o_pop_valid;
    assign o_pop_job    = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push_ok) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (pop_ok) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            unique case ({push_ok, pop_ok})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_push_job;
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue occupancy beyond its depth");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("job taken from an empty queue");

endmodule

>>> rtl/lrwcg_back.sv
// ----------------------------------------------------------------------------
// lrwcg_back: bus word sequencer
// Steps through the words of the job at the queue head, one a cycle, into
// an output register that holds while the receiver stalls.
// ----------------------------------------------------------------------------
module lrwcg_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_job_valid,
    input  lrwcg_pkg::t_job      i_job,
    output logic                 o_job_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output lrwcg_pkg::t_out_item o_out_data
);

    logic [lrwcg_pkg::STEP_W-1:0] r_step;
    logic                         r_out_valid;
    lrwcg_pkg::t_out_item         r_out;

    logic                           load;
    logic                           has_win;
    logic [lrwcg_pkg::STEP_W-1:0]   tail;
    logic [lrwcg_pkg::BUS_W-1:0]    sel_cmd;
    logic [lrwcg_pkg::COORD_W-1:0]  sel_coord;
    logic                           sel_is_coord;
    logic [lrwcg_pkg::BUS_W-1:0]    sel_data;
    logic [lrwcg_pkg::COUNT_W-1:0]  sel_count;
    logic                           sel_last;
    logic [lrwcg_pkg::COUNT_W-1:0]  sat_area;
    lrwcg_pkg::t_out_item           n_out;

    assign load        = i_job_valid && (!r_out_valid || i_out_ready);
    assign o_job_pop   = load && sel_last;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        sat_area = (i_job.area > lrwcg_pkg::AREA_W'(lrwcg_pkg::COUNT_MAX))
                 ? lrwcg_pkg::COUNT_MAX : i_job.area[lrwcg_pkg::COUNT_W-1:0];
        has_win  = (i_job.kind != lrwcg_pkg::JOB_PIXEL);
        tail     = has_win ? r_step - lrwcg_pkg::STEP_W'(lrwcg_pkg::WIN_WORDS) : r_step;
        sel_cmd      = lrwcg_pkg::CMD_RAM;
        sel_coord    = '0;
        sel_is_coord = 1'b0;
        sel_count    = lrwcg_pkg::COUNT_W'(1);
        sel_last     = 1'b0;
        if (has_win && (r_step < lrwcg_pkg::STEP_W'(lrwcg_pkg::WIN_WORDS))) begin
            sel_is_coord = 1'b1;
            unique case (r_step[lrwcg_pkg::STEP_W-1:1])
                4'd0: begin
                    sel_cmd   = lrwcg_pkg::CMD_WIN_X_START;
                    sel_coord = i_job.win.xs;
                end
                4'd1: begin
                    sel_cmd   = lrwcg_pkg::CMD_WIN_Y_START;
                    sel_coord = i_job.win.ys;
                end
                4'd2: begin
                    sel_cmd   = lrwcg_pkg::CMD_WIN_X_END;
                    sel_coord = i_job.win.xe;
                end
                4'd3: begin
                    sel_cmd   = lrwcg_pkg::CMD_WIN_Y_END;
                    sel_coord = i_job.win.ye;
                end
                4'd4: begin
                    sel_cmd   = lrwcg_pkg::CMD_CURSOR_X;
                    sel_coord = i_job.win.cx;
                end
                default: begin
                    sel_cmd   = lrwcg_pkg::CMD_CURSOR_Y;
                    sel_coord = i_job.win.cy;
                end
            endcase
        end else begin
            unique case (i_job.kind)
                lrwcg_pkg::JOB_FILL: begin
                    sel_count = tail[0] ? sat_area : lrwcg_pkg::COUNT_W'(1);
                    sel_last  = tail[0];
                end
                default: begin
                    sel_last = (tail == lrwcg_pkg::STEP_W'(5));
                    unique case (tail[lrwcg_pkg::STEP_W-1:1])
                        4'd0: begin
                            sel_cmd      = lrwcg_pkg::CMD_CURSOR_X;
                            sel_coord    = i_job.pix_cx;
                            sel_is_coord = 1'b1;
                        end
                        4'd1: begin
                            sel_cmd      = lrwcg_pkg::CMD_CURSOR_Y;
                            sel_coord    = i_job.pix_cy;
                            sel_is_coord = 1'b1;
                        end
                        default: begin
                            sel_cmd = lrwcg_pkg::CMD_RAM;
                        end
                    endcase
                end
            endcase
        end
        sel_data           = sel_is_coord ? lrwcg_pkg::BUS_W'(sel_coord) : i_job.color;
        n_out.is_command   = !r_step[0];
        n_out.bus_word     = r_step[0] ? sel_data : sel_cmd;
        n_out.repeat_count = sel_count;
        n_out.last         = sel_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                r_step      <= sel_last ? '0 : r_step + lrwcg_pkg::STEP_W'(1);
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= n_out;
        end
    end

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step < lrwcg_pkg::STEP_W'(lrwcg_pkg::MAX_WORDS))
        else $error("word sequencer ran past the longest job");

    a_repeat_on_fill_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out.repeat_count != lrwcg_pkg::COUNT_W'(1))
            |-> !r_out.is_command && r_out.last)
        else $error("repeated word is not the final data word of a fill");

endmodule

>>> rtl/lcd_rotated_window_command_gen_core.sv
// ----------------------------------------------------------------------------
// lcd_rotated_window_command_gen_core: rotated GRAM window command generator
// Turns pixel and fill requests in logical coordinates into the command and
// data words of a panel controller's graphics RAM port.
// ----------------------------------------------------------------------------
// A request transaction on the input channel carries the kind, the corners
// and the colour. Each produces a burst of output transactions, one bus word
// each, with last set on the final word. The configuration channel writes
// the rotation and is always ready; the user must write it only while the
// block is idle, which the block does not enforce. A request passes two
// front stages, the job queue and the output register before its first
// word is valid. While the receiver is ready, the back emits one word per
// cycle: six words for a pixel, eighteen for a pixel that restores the full
// window after a fill, fourteen for a fill. The output bus sets that rate,
// and requests are taken back to back while earlier words are still going
// out. Reset empties the pipeline and queue, sets the rotation to zero and
// assumes the full window is set. On a receiver stall the output register
// holds its word; the queue and front stages fill and then input ready falls.
// ----------------------------------------------------------------------------
module lcd_rotated_window_command_gen_core #(
    parameter int PANEL_WIDTH  = 240,
    parameter int PANEL_HEIGHT = 320,
    parameter int QUEUE_DEPTH  = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  lrwcg_pkg::t_in_item  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output lrwcg_pkg::t_out_item o_out_data
);

    lrwcg_pkg::t_rotation r_rotation;

    logic            push_valid, push_ready;
    lrwcg_pkg::t_job push_job;
    logic            head_valid, head_pop;
    lrwcg_pkg::t_job head_job;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rotation <= lrwcg_pkg::ROT_0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_rotation <= lrwcg_pkg::t_rotation'(i_cfg_data);
        end
    end

    lrwcg_front #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rotation  (r_rotation),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_job_valid (push_valid),
        .i_job_ready (push_ready),
        .o_job       (push_job)
    );

    lrwcg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_job   (push_job),
        .o_pop_valid  (head_valid),
        .i_pop        (head_pop),
        .o_pop_job    (head_job)
    );

    lrwcg_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (head_valid),
        .i_job       (head_job),
        .o_job_pop   (head_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

>>> tb/sv/lcd_rotated_window_command_gen_core_test.sv
// ----------------------------------------------------------------------------
// lcd_rotated_window_command_gen_core_test: self-checking bench for the core
// Sends pixel and fill requests under every rotation and works out the words
// each one should produce. Every output transaction is checked field by field
// against the oldest word still awaited. Both channels idle at random rates.
// ----------------------------------------------------------------------------
module lcd_rotated_window_command_gen_core_test;

    localparam int          PANEL_W     = 240;
    localparam int          PANEL_H     = 320;
    localparam int          CYCLE_LIMIT = 200000;
    localparam int          SEG_ITEMS   = 40;
    localparam int          SEGMENTS    = 12;
    localparam int          DRAIN_WAIT  = 30;
    localparam logic        OP_PIXEL    = 1'b0;
    localparam logic        OP_FILL     = 1'b1;

    logic                 i_clk     = 1'b0;
    logic                 i_rst_n   = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [1:0]           cfg_data  = 2'd0;
    logic                 cfg_ready;
    logic                 in_valid  = 1'b0;
    lrwcg_pkg::t_in_item  in_data   = '0;
    logic                 in_ready;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    lrwcg_pkg::t_out_item out_data;

    lrwcg_pkg::t_in_item  pending_requests[$];
    lrwcg_pkg::t_out_item expected_words[$];
    lrwcg_pkg::t_out_item oldest_word;
    lrwcg_pkg::t_rotation gram_rotation   = lrwcg_pkg::ROT_0;
    bit                   window_narrowed = 1'b0;
    int unsigned          send_idle_pct   = 31;
    int unsigned          recv_idle_pct   = 59;
    int                   error_count     = 0;
    int                   cycle_count     = 0;

    lcd_rotated_window_command_gen_core #(
        .PANEL_WIDTH (PANEL_W),
        .PANEL_HEIGHT(PANEL_H)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_data (cfg_data),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("lcd_rotated_window_command_gen_core test failed");
            $finish;
        end
    end

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        error_count++;
        $display("ERROR cycle %0d: %s got 0x%0h expected 0x%0h",
                 cycle_count, what, got, want);
    endtask

    function automatic void push_word(bit cmd, logic [15:0] word, logic [16:0] rep, bit fin);
        lrwcg_pkg::t_out_item w;
        w.is_command   = cmd;
        w.bus_word     = word;
        w.repeat_count = rep;
        w.last         = fin;
        expected_words.push_back(w);
    endfunction

    function automatic void push_reg(logic [15:0] idx, int unsigned val);
        push_word(1'b1, idx, 17'd1, 1'b0);
        push_word(1'b0, 16'(val), 17'd1, 1'b0);
    endfunction

    function automatic int unsigned clamp_coord(int unsigned v, int unsigned lim);
        return (v > lim - 1) ? lim - 1 : v;
    endfunction

    // Maps a logical window onto the panel and queues its six register writes.
    function automatic void push_window(int unsigned lx, int unsigned ly,
                                        int unsigned hx, int unsigned hy);
        int unsigned plx, ply, phx, phy, cx, cy;
        window_narrowed = 1'b1;
        case (gram_rotation)
            lrwcg_pkg::ROT_90: begin
                plx = PANEL_W - 1 - hy; phx = PANEL_W - 1 - ly;
                ply = lx;               phy = hx;
                cx  = phx;              cy  = ply;
            end
            lrwcg_pkg::ROT_180: begin
                plx = PANEL_W - 1 - hx; phx = PANEL_W - 1 - lx;
                ply = PANEL_H - 1 - hy; phy = PANEL_H - 1 - ly;
                cx  = phx;              cy  = phy;
            end
            lrwcg_pkg::ROT_270: begin
                plx = ly;               phx = hy;
                ply = PANEL_H - 1 - hx; phy = PANEL_H - 1 - lx;
                cx  = plx;              cy  = phy;
            end
            default: begin
                plx = lx; ply = ly; phx = hx; phy = hy;
                cx  = lx; cy  = ly;
            end
        endcase
        push_reg(lrwcg_pkg::CMD_WIN_X_START, plx);
        push_reg(lrwcg_pkg::CMD_WIN_Y_START, ply);
        push_reg(lrwcg_pkg::CMD_WIN_X_END, phx);
        push_reg(lrwcg_pkg::CMD_WIN_Y_END, phy);
        push_reg(lrwcg_pkg::CMD_CURSOR_X, cx);
        push_reg(lrwcg_pkg::CMD_CURSOR_Y, cy);
    endfunction

    function automatic void predict_request(lrwcg_pkg::t_in_item req);
        bit          swap_axes;
        int unsigned lw, lh, xl, yl, xh, yh, px, py, t, n;
        swap_axes = (gram_rotation == lrwcg_pkg::ROT_90) ||
                    (gram_rotation == lrwcg_pkg::ROT_270);
        lw = swap_axes ? PANEL_H : PANEL_W;
        lh = swap_axes ? PANEL_W : PANEL_H;
        xl = clamp_coord(32'(req.x_low), lw);
        yl = clamp_coord(32'(req.y_low), lh);
        xh = clamp_coord(32'(req.x_high), lw);
        yh = clamp_coord(32'(req.y_high), lh);
        if (req.op == OP_PIXEL) begin
            if (window_narrowed) begin
                push_window(0, 0, lw - 1, lh - 1);
                window_narrowed = 1'b0;
            end
            case (gram_rotation)
                lrwcg_pkg::ROT_90:  begin px = PANEL_W - 1 - yl; py = xl; end
                lrwcg_pkg::ROT_180: begin px = PANEL_W - 1 - xl; py = PANEL_H - 1 - yl; end
                lrwcg_pkg::ROT_270: begin px = yl; py = PANEL_H - 1 - xl; end
                default:            begin px = xl; py = yl; end
            endcase
            push_reg(lrwcg_pkg::CMD_CURSOR_X, px);
            push_reg(lrwcg_pkg::CMD_CURSOR_Y, py);
            push_word(1'b1, lrwcg_pkg::CMD_RAM, 17'd1, 1'b0);
            push_word(1'b0, req.color, 17'd1, 1'b1);
        end else begin
            if (xl > xh) begin t = xl; xl = xh; xh = t; end
            if (yl > yh) begin t = yl; yl = yh; yh = t; end
            n = (xh - xl + 1) * (yh - yl + 1);
            if (n > lrwcg_pkg::COUNT_MAX) n = lrwcg_pkg::COUNT_MAX;
            push_window(xl, yl, xh, yh);
            push_word(1'b1, lrwcg_pkg::CMD_RAM, 17'd1, 1'b0);
            push_word(1'b0, req.color, 17'(n), 1'b1);
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                predict_request(in_data);
            end
            if (!in_valid || in_ready) begin
                if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    in_data  <= pending_requests.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_words.size() == 0) begin
                    report_mismatch("unexpected word", 32'(out_data.bus_word), 0);
                end else begin
                    oldest_word = expected_words.pop_front();
                    if (out_data.is_command !== oldest_word.is_command)
                        report_mismatch("is_command", 32'(out_data.is_command),
                                        32'(oldest_word.is_command));
                    if (out_data.bus_word !== oldest_word.bus_word)
                        report_mismatch("bus_word", 32'(out_data.bus_word),
                                        32'(oldest_word.bus_word));
                    if (out_data.repeat_count !== oldest_word.repeat_count)
                        report_mismatch("repeat_count", 32'(out_data.repeat_count),
                                        32'(oldest_word.repeat_count));
                    if (out_data.last !== oldest_word.last)
                        report_mismatch("last", 32'(out_data.last), 32'(oldest_word.last));
                end
            end
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic add_request(logic op, int unsigned xl, int unsigned yl,
                               int unsigned xh, int unsigned yh, int unsigned color);
        lrwcg_pkg::t_in_item req;
        req.op     = op;
        req.x_low  = 9'(xl);
        req.y_low  = 9'(yl);
        req.x_high = 9'(xh);
        req.y_high = 9'(yh);
        req.color  = 16'(color);
        pending_requests.push_back(req);
    endtask

    function automatic logic [8:0] rand_coord();
        int unsigned pick;
        pick = $urandom_range(0, 19);
        if (pick < 13) return 9'($urandom_range(0, 319));
        if (pick < 16) begin
            case ($urandom_range(0, 3))
                0:       return 9'd0;
                1:       return 9'd239;
                2:       return 9'd240;
                default: return 9'd319;
            endcase
        end
        return 9'($urandom_range(0, 511));
    endfunction

    task automatic add_random_request();
        add_request(1'($urandom_range(0, 1)), rand_coord(), rand_coord(),
                    rand_coord(), rand_coord(), $urandom_range(0, 65535));
    endtask

    task automatic drain_all();
        while (pending_requests.size() != 0 || in_valid || expected_words.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_rotation(lrwcg_pkg::t_rotation rot);
        cfg_data  <= rot;
        cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!(cfg_valid && cfg_ready));
        cfg_valid     <= 1'b0;
        gram_rotation = rot;
    endtask

    initial begin
        int seg;
        int k;
        int r;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        add_request(OP_PIXEL, 0, 0, 0, 0, 16'h0000);
        add_request(OP_PIXEL, 239, 319, 511, 511, 16'hFFFF);
        add_request(OP_FILL, 200, 300, 5, 7, 16'h1234);
        add_request(OP_PIXEL, 256, 128, 0, 0, 16'hA5A5);
        add_request(OP_FILL, 100, 100, 100, 100, 16'h5A5A);
        add_request(OP_FILL, 0, 319, 239, 0, 16'h8001);
        add_request(OP_PIXEL, 255, 255, 256, 256, 16'h7FFE);
        add_request(OP_PIXEL, 1, 1, 1, 1, 16'hFFFF);
        drain_all();

        for (r = 0; r < 4; r++) begin
            write_rotation(lrwcg_pkg::t_rotation'(r));
            add_request(OP_PIXEL, 0, 0, 0, 0, 16'hC3C3);
            add_request(OP_FILL, 0, 0, 511, 511, 16'h3C3C);
            add_request(OP_PIXEL, 511, 511, 0, 0, 16'h0F0F);
            add_request(OP_FILL, 3, 9, 1, 2, 16'hF0F0);
            drain_all();
        end

        for (seg = 0; seg < SEGMENTS; seg++) begin
            case (seg / 4)
                0:       begin send_idle_pct <= 31; recv_idle_pct <= 59; end
                1:       begin send_idle_pct <= 59; recv_idle_pct <= 31; end
                default: begin send_idle_pct <= 0;  recv_idle_pct <= 0;  end
            endcase
            write_rotation(lrwcg_pkg::t_rotation'((seg * 3 + seg / 4) % 4));
            for (k = 0; k < SEG_ITEMS; k++) add_random_request();
            drain_all();
        end

        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (expected_words.size() != 0)
            report_mismatch("words never produced", expected_words.size(), 0);
        if (error_count == 0) begin
            $display("lcd_rotated_window_command_gen_core test passed");
        end else begin
            $display("lcd_rotated_window_command_gen_core test failed");
        end
        $finish;
    end

endmodule
